FILE: rtl/msc_pkg.sv
package msc_pkg;

    // Fixed field widths
    localparam int CFG_W     = 5;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 36;
    localparam int VERDICT_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

    // Verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_MAGIC   = 2'd0,
        VERDICT_REPEAT  = 2'd1,
        VERDICT_UNEQUAL = 2'd2
    } verdict_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ROW,
        ST_COL,
        ST_DIAG,
        ST_ANTI,
        ST_ROWEND,
        ST_CHK_COL,
        ST_CHK_MAIN,
        ST_CHK_ANTI,
        ST_VERDICT
    } state_t;

    // Target of the shared adder
    typedef enum logic [2:0] {
        ADD_NONE,
        ADD_ROW,
        ADD_COL,
        ADD_MAIN,
        ADD_ANTI
    } add_sel_t;

    // Operand pair of the shared comparator
    typedef enum logic [2:0] {
        CMP_ELEM,
        CMP_ROW,
        CMP_COL,
        CMP_MAIN,
        CMP_ANTI
    } cmp_sel_t;

    // Sequencer to datapath control
    typedef struct packed {
        add_sel_t add_sel;
        cmp_sel_t cmp_sel;
        logic     clear;
        logic     row_clear;
        logic     first_load;
    } dp_ctrl_t;

endpackage

FILE: rtl/msc_elem_mem.sv
module msc_elem_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [msc_pkg::VAL_W-1:0]   wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [msc_pkg::VAL_W-1:0]   rdata
);

    logic [msc_pkg::VAL_W-1:0] mem [DEPTH];
    logic [msc_pkg::VAL_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/msc_datapath.sv
module msc_datapath #(
    parameter int MAX_SIDE = 16,
    parameter int IDX_W    = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  msc_pkg::dp_ctrl_t           ctrl,
    input  logic [IDX_W-1:0]            col_idx,
    input  logic [msc_pkg::VAL_W-1:0]   value,
    input  logic [msc_pkg::VAL_W-1:0]   elem_data,
    output logic                        equal
);

    logic [msc_pkg::SUM_W-1:0] col_sums_reg [MAX_SIDE];
    logic [msc_pkg::SUM_W-1:0] row_sum_reg;
    logic [msc_pkg::SUM_W-1:0] first_sum_reg;
    logic [msc_pkg::SUM_W-1:0] main_sum_reg;
    logic [msc_pkg::SUM_W-1:0] anti_sum_reg;

    logic [msc_pkg::SUM_W-1:0] col_rd;
    logic [msc_pkg::SUM_W-1:0] add_a;
    logic [msc_pkg::SUM_W-1:0] add_sum;
    logic [msc_pkg::SUM_W-1:0] cmp_a;
    logic [msc_pkg::SUM_W-1:0] cmp_b;

    // One column read address, shared by accumulate and final check
    assign col_rd = col_sums_reg[col_idx];

    // Shared adder, wraps at the sum width
    always_comb
    begin
        case (ctrl.add_sel)
            msc_pkg::ADD_ROW:  add_a = row_sum_reg;
            msc_pkg::ADD_COL:  add_a = col_rd;
            msc_pkg::ADD_MAIN: add_a = main_sum_reg;
            msc_pkg::ADD_ANTI: add_a = anti_sum_reg;
            default:           add_a = '0;
        endcase
    end

    assign add_sum = add_a + msc_pkg::SUM_W'(value);

    // Shared equality compare
    always_comb
    begin
        cmp_b = first_sum_reg;
        case (ctrl.cmp_sel)
            msc_pkg::CMP_ELEM:
            begin
                cmp_a = msc_pkg::SUM_W'(elem_data);
                cmp_b = msc_pkg::SUM_W'(value);
            end
            msc_pkg::CMP_ROW:  cmp_a = row_sum_reg;
            msc_pkg::CMP_COL:  cmp_a = col_rd;
            msc_pkg::CMP_MAIN: cmp_a = main_sum_reg;
            msc_pkg::CMP_ANTI: cmp_a = anti_sum_reg;
            default:           cmp_a = '0;
        endcase
    end

    assign equal = (cmp_a == cmp_b);

    // Sum registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SIDE; i++)
            begin
                col_sums_reg[i] <= '0;
            end
            row_sum_reg   <= '0;
            first_sum_reg <= '0;
            main_sum_reg  <= '0;
            anti_sum_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < MAX_SIDE; i++)
            begin
                col_sums_reg[i] <= '0;
            end
            row_sum_reg   <= '0;
            first_sum_reg <= '0;
            main_sum_reg  <= '0;
            anti_sum_reg  <= '0;
        end
        else
        begin
            case (ctrl.add_sel)
                msc_pkg::ADD_ROW:  row_sum_reg           <= add_sum;
                msc_pkg::ADD_COL:  col_sums_reg[col_idx] <= add_sum;
                msc_pkg::ADD_MAIN: main_sum_reg          <= add_sum;
                msc_pkg::ADD_ANTI: anti_sum_reg          <= add_sum;
                default:           ;
            endcase
            if (ctrl.first_load)
            begin
                first_sum_reg <= row_sum_reg;
            end
            if (ctrl.row_clear)
            begin
                row_sum_reg <= '0;
            end
        end
    end

endmodule

FILE: rtl/magic_square_checker.sv
// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  -----------------------------
// entry     in         in_valid / in_stall       entry_value[31:0]
// verdict   out        out_valid / out_stall     verdict[1:0]
// config    in         matrix_size_we            matrix_size[4:0]
//
// Each entry is handled in order: every stored entry is read and compared through
// the single memory read port (none for the first entry), the read is drained,
// then the shared adder and comparator step through row, column and both diagonals.
// The last entry adds the column and diagonal checks and the verdict. Reset clears
// all sums and counters and sets the side length to 3.
// A pending verdict is held in the output register; only a following verdict
// waits on out_stall.
module magic_square_checker #(
    parameter int MAX_SIDE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          matrix_size_we,
    input  logic [msc_pkg::CFG_W-1:0]     matrix_size,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [msc_pkg::VAL_W-1:0]     entry_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [msc_pkg::VERDICT_W-1:0] verdict
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);

    msc_pkg::state_t   state_reg, state_next;
    msc_pkg::verdict_t verdict_reg, verdict_next;
    msc_pkg::dp_ctrl_t dp_ctrl;

    logic [msc_pkg::CFG_W-1:0] msize_reg, msize_next;
    logic [msc_pkg::VAL_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic [ADDR_W-1:0]         k_reg, k_next;
    logic [IDX_W-1:0]          row_reg, row_next;
    logic [IDX_W-1:0]          col_reg, col_next;
    logic                      dup_reg, dup_next;
    logic                      mismatch_reg, mismatch_next;
    logic                      pend_reg, pend_next;
    logic                      out_valid_reg, out_valid_next;

    logic [SIDE_W-1:0]         side;
    logic [IDX_W-1:0]          n_m1;
    logic                      last_col;
    logic                      last_row;
    logic                      on_main;
    logic                      on_anti;
    logic                      scan_done;
    logic                      verdict_fire;
    logic                      in_fire;
    logic                      equal;
    logic [IDX_W-1:0]          col_idx;
    logic                      mem_we;
    logic                      mem_re;
    logic [msc_pkg::VAL_W-1:0] mem_rdata;

    // Side length with out-of-range sizes clamped
    always_comb
    begin
        if (msize_reg == '0)
        begin
            side = SIDE_W'(1);
        end
        else if (int'(msize_reg) > MAX_SIDE)
        begin
            side = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side = SIDE_W'(msize_reg);
        end
    end

    // Position decode
    assign n_m1      = IDX_W'(side - SIDE_W'(1));
    assign last_col  = (col_reg == n_m1);
    assign last_row  = (row_reg == n_m1);
    assign on_main   = (row_reg == col_reg);
    assign on_anti   = ((IDX_W+1)'(row_reg) + (IDX_W+1)'(col_reg)) == (IDX_W+1)'(n_m1);
    assign scan_done = (ADDR_W'(k_reg + 1'b1) == idx_reg);

    assign in_fire      = in_valid && !in_stall;
    assign verdict_fire = (state_reg == msc_pkg::ST_VERDICT) && (!out_valid_reg || !out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            msc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (idx_reg == '0) ? msc_pkg::ST_ROW : msc_pkg::ST_SCAN;
                end
            end
            msc_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = msc_pkg::ST_DRAIN;
                end
            end
            msc_pkg::ST_DRAIN:    state_next = msc_pkg::ST_ROW;
            msc_pkg::ST_ROW:      state_next = msc_pkg::ST_COL;
            msc_pkg::ST_COL:      state_next = msc_pkg::ST_DIAG;
            msc_pkg::ST_DIAG:     state_next = msc_pkg::ST_ANTI;
            msc_pkg::ST_ANTI:     state_next = msc_pkg::ST_ROWEND;
            msc_pkg::ST_ROWEND:
            begin
                state_next = (last_row && last_col) ? msc_pkg::ST_CHK_COL : msc_pkg::ST_IDLE;
            end
            msc_pkg::ST_CHK_COL:
            begin
                if (k_reg[IDX_W-1:0] == n_m1)
                begin
                    state_next = msc_pkg::ST_CHK_MAIN;
                end
            end
            msc_pkg::ST_CHK_MAIN: state_next = msc_pkg::ST_CHK_ANTI;
            msc_pkg::ST_CHK_ANTI: state_next = msc_pkg::ST_VERDICT;
            msc_pkg::ST_VERDICT:
            begin
                if (verdict_fire)
                begin
                    state_next = msc_pkg::ST_IDLE;
                end
            end
            default:              state_next = msc_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall           = 1'b1;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        col_idx            = col_reg;
        dp_ctrl.add_sel    = msc_pkg::ADD_NONE;
        dp_ctrl.cmp_sel    = msc_pkg::CMP_ELEM;
        dp_ctrl.clear      = matrix_size_we;
        dp_ctrl.row_clear  = 1'b0;
        dp_ctrl.first_load = 1'b0;
        unique case (state_reg)
            msc_pkg::ST_IDLE:     in_stall = 1'b0;
            msc_pkg::ST_SCAN:     mem_re   = 1'b1;
            msc_pkg::ST_DRAIN:    ;
            msc_pkg::ST_ROW:
            begin
                mem_we          = 1'b1;
                dp_ctrl.add_sel = msc_pkg::ADD_ROW;
            end
            msc_pkg::ST_COL:      dp_ctrl.add_sel = msc_pkg::ADD_COL;
            msc_pkg::ST_DIAG:
            begin
                if (on_main)
                begin
                    dp_ctrl.add_sel = msc_pkg::ADD_MAIN;
                end
            end
            msc_pkg::ST_ANTI:
            begin
                if (on_anti)
                begin
                    dp_ctrl.add_sel = msc_pkg::ADD_ANTI;
                end
            end
            msc_pkg::ST_ROWEND:
            begin
                dp_ctrl.cmp_sel = msc_pkg::CMP_ROW;
                if (last_col)
                begin
                    dp_ctrl.row_clear  = 1'b1;
                    dp_ctrl.first_load = (row_reg == '0);
                end
            end
            msc_pkg::ST_CHK_COL:
            begin
                dp_ctrl.cmp_sel = msc_pkg::CMP_COL;
                col_idx         = k_reg[IDX_W-1:0];
            end
            msc_pkg::ST_CHK_MAIN: dp_ctrl.cmp_sel = msc_pkg::CMP_MAIN;
            msc_pkg::ST_CHK_ANTI: dp_ctrl.cmp_sel = msc_pkg::CMP_ANTI;
            msc_pkg::ST_VERDICT:  dp_ctrl.clear   = verdict_fire;
            default:              ;
        endcase
    end

    // Counters, flags and output register
    always_comb
    begin
        msize_next     = msize_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        dup_next       = dup_reg;
        mismatch_next  = mismatch_reg;
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        pend_next      = (state_reg == msc_pkg::ST_SCAN);

        // drained verdict leaves the output register
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // stored entry compare, in the cycle after the read
        if (pend_reg && equal)
        begin
            dup_next = 1'b1;
        end

        case (state_reg) inside
            msc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    value_next = entry_value;
                    k_next     = '0;
                end
            end
            msc_pkg::ST_SCAN:
            begin
                k_next = ADDR_W'(k_reg + 1'b1);
            end
            msc_pkg::ST_ROWEND:
            begin
                if (last_col && (row_reg != '0) && !equal)
                begin
                    mismatch_next = 1'b1;
                end
                if (last_col)
                begin
                    col_next = '0;
                    row_next = IDX_W'(row_reg + 1'b1);
                end
                else
                begin
                    col_next = IDX_W'(col_reg + 1'b1);
                end
                idx_next = ADDR_W'(idx_reg + 1'b1);
                k_next   = '0;
            end
            msc_pkg::ST_CHK_COL:
            begin
                if (!equal)
                begin
                    mismatch_next = 1'b1;
                end
                k_next = ADDR_W'(k_reg + 1'b1);
            end
            msc_pkg::ST_CHK_MAIN, msc_pkg::ST_CHK_ANTI:
            begin
                if (!equal)
                begin
                    mismatch_next = 1'b1;
                end
            end
            msc_pkg::ST_VERDICT:
            begin
                if (verdict_fire)
                begin
                    out_valid_next = 1'b1;
                    if (dup_reg)
                    begin
                        verdict_next = msc_pkg::VERDICT_REPEAT;
                    end
                    else if (mismatch_reg)
                    begin
                        verdict_next = msc_pkg::VERDICT_UNEQUAL;
                    end
                    else
                    begin
                        verdict_next = msc_pkg::VERDICT_MAGIC;
                    end
                    idx_next      = '0;
                    row_next      = '0;
                    col_next      = '0;
                    dup_next      = 1'b0;
                    mismatch_next = 1'b0;
                end
            end
            default: ;
        endcase

        // size write drops the partial matrix
        if (matrix_size_we)
        begin
            msize_next    = matrix_size;
            idx_next      = '0;
            row_next      = '0;
            col_next      = '0;
            dup_next      = 1'b0;
            mismatch_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msc_pkg::ST_IDLE;
            msize_reg     <= msc_pkg::CFG_RESET;
            idx_reg       <= '0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            dup_reg       <= 1'b0;
            mismatch_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            msize_reg     <= msize_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            dup_reg       <= dup_next;
            mismatch_reg  <= mismatch_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        verdict_reg <= verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    // Entry store
    msc_elem_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (value_reg),
        .re    (mem_re),
        .raddr (k_reg),
        .rdata (mem_rdata)
    );

    // Sums, shared adder and comparator
    msc_datapath #(
        .MAX_SIDE (MAX_SIDE),
        .IDX_W    (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dp_ctrl),
        .col_idx   (col_idx),
        .value     (value_reg),
        .elem_data (mem_rdata),
        .equal     (equal)
    );

    // A verdict only appears out of the verdict state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == msc_pkg::ST_VERDICT)
        else $error("verdict raised outside the verdict state");

    // The scan never reads at or past the slot being filled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msc_pkg::ST_SCAN) |-> (k_reg < idx_reg))
        else $error("scan address beyond stored entries");

    // Between transactions the row counter stays inside the matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msc_pkg::ST_IDLE) |-> ((SIDE_W+1)'(row_reg) < (SIDE_W+1)'(side)))
        else $error("row counter outside the matrix while idle");

endmodule
